// ===== rtl/video_payload_frame_reassembler_assert.svh =====
`ifndef VIDEO_PAYLOAD_FRAME_REASSEMBLER_ASSERT_SVH
`define VIDEO_PAYLOAD_FRAME_REASSEMBLER_ASSERT_SVH

// implication checked outside reset
`define VPFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpfr port check failed");

// next-cycle implication checked outside reset
`define VPFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpfr port check failed");

// next-cycle implication that also spans reset
`define VPFR_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vpfr reset check failed");

`endif

// ===== rtl/vpfr_pkg.sv =====
package vpfr_pkg;

  localparam logic [2:0] REQ_BYTE  = 3'd0;
  localparam logic [2:0] REQ_TERR  = 3'd1;
  localparam logic [2:0] REQ_READ  = 3'd2;
  localparam logic [2:0] REQ_STAT  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_STAT   = 2'd2;

  localparam logic [2:0] RES_ACCEPTED = 3'd0;
  localparam logic [2:0] RES_FRAME    = 3'd1;
  localparam logic [2:0] RES_INVALID  = 3'd2;
  localparam logic [2:0] RES_ERROR    = 3'd3;
  localparam logic [2:0] RES_OVERFLOW = 3'd4;

  localparam int ST_PACKETS   = 0;
  localparam int ST_INVALID   = 1;
  localparam int ST_ERROR     = 2;
  localparam int ST_EOF       = 3;
  localparam int ST_TOGGLES   = 4;
  localparam int ST_OVERFLOWS = 5;
  localparam int ST_BYTES     = 6;
  localparam int ST_FRAMES    = 7;
  localparam int ST_TRANSPORT = 8;
  localparam int NSTAT        = 9;

  localparam logic [21:0] PKT_MAX = 22'h3FFFFF;
  localparam logic [20:0] CAP_RESET = 21'd1048576;
  localparam logic [7:0] HDR_MIN = 8'd2;
  localparam int FLAG_FID = 0;
  localparam int FLAG_EOF = 1;
  localparam int FLAG_ERR = 6;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [19:0] read_index;
    logic [3:0]  stat_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [2:0]  result_code;
    logic [20:0] frame_length;
    logic [47:0] read_data;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic        cur_bank;
    logic [20:0] cur_len;
    logic [20:0] cmp_len;
    logic        cmp_bank;
    logic        bad;
    logic [1:0]  frames;
  } frame_state_t;

  function automatic frame_state_t close_frame(frame_state_t s);
    frame_state_t r;
    r = s;
    if (s.cur_len != '0 && !s.bad) begin
      r.cmp_len  = s.cur_len;
      r.cmp_bank = s.cur_bank;
      r.frames   = s.frames + 2'd1;
    end else begin
      r.cmp_len = '0;
    end
    r.cur_bank = ~s.cur_bank;
    r.cur_len  = '0;
    r.bad      = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/vpfr_store.sv =====
module vpfr_store #(
  parameter int AW = 20
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW:0]   wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW:0]   rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [2**(AW+1)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/video_payload_frame_reassembler.sv =====
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    in_data  (vpfr_pkg::in_item_t)
// out       out   out_valid / out_ready  out_data (vpfr_pkg::out_item_t)
// cfg       in    cfg_we                 cfg_wdata (capacity)
// one item per cycle while in_ready is high; a result shows in the cycle after its transfer
// frame byte reads come from the store's registered read port
// in_ready drops only while a result waits and out_ready is low
// rst_n is synchronous; the frame store is not cleared
module video_payload_frame_reassembler #(
  parameter int FRAME_BYTES = 1048576
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vpfr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vpfr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [20:0]         cfg_wdata
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [25:0] FB26 = 26'(FRAME_BYTES);

  logic [20:0] cap_r;
  logic        fid_seen_r, fid_seen_nxt;
  logic        last_fid_r, last_fid_nxt;
  logic [21:0] pbc_r, pbc_nxt;
  logic [7:0]  hlen_r, hlen_nxt;
  logic [7:0]  hflags_r, hflags_nxt;
  logic        spec_bank_r, spec_bank_nxt;
  logic [20:0] spec_base_r, spec_base_nxt;
  vpfr_pkg::frame_state_t fs_r, fs_nxt;
  logic [47:0] stat_r [vpfr_pkg::NSTAT];
  logic [47:0] stat_nxt [vpfr_pkg::NSTAT];
  logic [21:0] inc [vpfr_pkg::NSTAT];

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  code_r, code_nxt;
  logic [20:0] flen_r, flen_nxt;
  logic [47:0] sval_r, sval_nxt;
  logic        oor_r, oor_nxt;

  logic        acc;
  logic [21:0] pos, len, payload;
  logic [25:0] waddr, cap26;
  logic [20:0] cap21, room;
  logic [7:0]  hl, fl;
  logic        done, has_res;
  logic        wr_en, rd_en;
  logic [24:0] ridx25;
  logic [7:0]  rd_data;

  assign acc      = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign ridx25   = {5'b0, in_data.read_index};
  assign cap26    = ({5'b0, cap_r} < FB26) ? {5'b0, cap_r} : FB26;
  assign cap21    = cap26[20:0];

  always_comb begin
    fid_seen_nxt  = fid_seen_r;
    last_fid_nxt  = last_fid_r;
    pbc_nxt       = pbc_r;
    hlen_nxt      = hlen_r;
    hflags_nxt    = hflags_r;
    spec_bank_nxt = spec_bank_r;
    spec_base_nxt = spec_base_r;
    fs_nxt        = fs_r;
    fs_nxt.frames = 2'd0;
    for (int i = 0; i < vpfr_pkg::NSTAT; i++) inc[i] = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt = kind_r;
    code_nxt = code_r;
    flen_nxt = flen_r;
    sval_nxt = sval_r;
    oor_nxt  = oor_r;
    has_res  = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    waddr    = '0;
    pos      = '0;
    len      = '0;
    payload  = '0;
    room     = '0;
    hl       = hlen_r;
    fl       = hflags_r;
    done     = 1'b0;
    if (acc) begin
      unique case (in_data.req_type)
        vpfr_pkg::REQ_BYTE: begin
          if (in_data.first_byte || pbc_r == '0) begin
            pos = '0;
            fs_nxt.cmp_len = '0;
          end else begin
            pos = pbc_r;
          end
          if (pos == 22'd0) begin
            hlen_nxt = in_data.data_byte;
          end else if (pos == 22'd1) begin
            hflags_nxt = in_data.data_byte;
            if (fid_seen_r && in_data.data_byte[vpfr_pkg::FLAG_FID] != last_fid_r
                && fs_r.cur_len != '0) begin
              spec_bank_nxt = ~fs_r.cur_bank;
              spec_base_nxt = '0;
            end else begin
              spec_bank_nxt = fs_r.cur_bank;
              spec_base_nxt = fs_r.cur_len;
            end
          end else if (pos >= {14'b0, hlen_r}) begin
            waddr = {5'b0, spec_base_r} + {4'b0, pos - {14'b0, hlen_r}};
            wr_en = waddr < FB26;
          end
          pbc_nxt = (pos < vpfr_pkg::PKT_MAX) ? pos + 22'd1 : pos;
          if (in_data.last_byte) begin
            has_res = 1'b1;
            len = pbc_nxt;
            pbc_nxt = '0;
            hl = hlen_nxt;
            fl = hflags_nxt;
            inc[vpfr_pkg::ST_PACKETS] = 22'd1;
            if (len < 22'd2 || hl < vpfr_pkg::HDR_MIN || {14'b0, hl} > len) begin
              inc[vpfr_pkg::ST_INVALID] = 22'd1;
              fs_nxt.bad = 1'b1;
              code_nxt = vpfr_pkg::RES_INVALID;
            end else begin
              if (!fid_seen_r) begin
                fid_seen_nxt = 1'b1;
                last_fid_nxt = fl[vpfr_pkg::FLAG_FID];
              end else if (fl[vpfr_pkg::FLAG_FID] != last_fid_r) begin
                inc[vpfr_pkg::ST_TOGGLES] = 22'd1;
                if (fs_nxt.cur_len != '0) begin
                  fs_nxt = vpfr_pkg::close_frame(fs_nxt);
                  done = fs_nxt.cmp_len != '0;
                end
                last_fid_nxt = fl[vpfr_pkg::FLAG_FID];
              end
              if (fl[vpfr_pkg::FLAG_ERR]) begin
                inc[vpfr_pkg::ST_ERROR] = 22'd1;
                fs_nxt.bad = 1'b1;
                if (fl[vpfr_pkg::FLAG_EOF]) begin
                  inc[vpfr_pkg::ST_EOF] = 22'd1;
                  if (done) begin
                    fs_nxt.cur_len = '0;
                    fs_nxt.bad = 1'b0;
                  end else begin
                    fs_nxt = vpfr_pkg::close_frame(fs_nxt);
                  end
                end
                code_nxt = done ? vpfr_pkg::RES_FRAME : vpfr_pkg::RES_ERROR;
              end else begin
                payload = len - {14'b0, hl};
                room = cap21 - ((fs_nxt.cur_len < cap21) ? fs_nxt.cur_len : cap21);
                if (payload > {1'b0, room}) begin
                  inc[vpfr_pkg::ST_OVERFLOWS] = 22'd1;
                  fs_nxt.cur_len = '0;
                  fs_nxt.bad = 1'b1;
                  code_nxt = done ? vpfr_pkg::RES_FRAME : vpfr_pkg::RES_OVERFLOW;
                end else begin
                  fs_nxt.cur_len = fs_nxt.cur_len + payload[20:0];
                  inc[vpfr_pkg::ST_BYTES] = payload;
                  if (fl[vpfr_pkg::FLAG_EOF]) begin
                    inc[vpfr_pkg::ST_EOF] = 22'd1;
                    fs_nxt = vpfr_pkg::close_frame(fs_nxt);
                    done = fs_nxt.cmp_len != '0;
                  end
                  code_nxt = done ? vpfr_pkg::RES_FRAME : vpfr_pkg::RES_ACCEPTED;
                end
              end
            end
            kind_nxt = vpfr_pkg::KIND_STATUS;
            flen_nxt = (code_nxt == vpfr_pkg::RES_FRAME) ? fs_nxt.cmp_len : '0;
            sval_nxt = '0;
            oor_nxt  = 1'b0;
          end
        end
        vpfr_pkg::REQ_TERR: begin
          inc[vpfr_pkg::ST_TRANSPORT] = 22'd1;
          fs_nxt.bad = 1'b1;
        end
        vpfr_pkg::REQ_READ: begin
          has_res  = 1'b1;
          kind_nxt = vpfr_pkg::KIND_BYTE;
          code_nxt = vpfr_pkg::RES_ACCEPTED;
          flen_nxt = '0;
          sval_nxt = '0;
          rd_en    = {6'b0, in_data.read_index} < {5'b0, fs_r.cmp_len}
                     && {6'b0, in_data.read_index} < FB26;
          oor_nxt  = !rd_en;
        end
        vpfr_pkg::REQ_STAT: begin
          has_res  = 1'b1;
          kind_nxt = vpfr_pkg::KIND_STAT;
          code_nxt = vpfr_pkg::RES_ACCEPTED;
          flen_nxt = '0;
          if (in_data.stat_index < 4'(vpfr_pkg::NSTAT)) begin
            sval_nxt = stat_r[in_data.stat_index];
            oor_nxt  = 1'b0;
          end else begin
            sval_nxt = '0;
            oor_nxt  = 1'b1;
          end
        end
        default: begin
        end
      endcase
      inc[vpfr_pkg::ST_FRAMES] = {20'b0, fs_nxt.frames};
      out_valid_nxt = has_res;
    end
    for (int i = 0; i < vpfr_pkg::NSTAT; i++) stat_nxt[i] = stat_r[i] + {26'b0, inc[i]};
    fs_nxt.frames = 2'd0;
    if (acc && in_data.req_type == vpfr_pkg::REQ_CLEAR) begin
      fid_seen_nxt  = 1'b0;
      last_fid_nxt  = 1'b0;
      pbc_nxt       = '0;
      hlen_nxt      = '0;
      hflags_nxt    = '0;
      spec_bank_nxt = 1'b0;
      spec_base_nxt = '0;
      fs_nxt        = '0;
      for (int i = 0; i < vpfr_pkg::NSTAT; i++) stat_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= vpfr_pkg::CAP_RESET;
      fid_seen_r  <= 1'b0;
      last_fid_r  <= 1'b0;
      pbc_r       <= '0;
      hlen_r      <= '0;
      hflags_r    <= '0;
      spec_bank_r <= 1'b0;
      spec_base_r <= '0;
      fs_r        <= '0;
      for (int i = 0; i < vpfr_pkg::NSTAT; i++) stat_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      fid_seen_r  <= fid_seen_nxt;
      last_fid_r  <= last_fid_nxt;
      pbc_r       <= pbc_nxt;
      hlen_r      <= hlen_nxt;
      hflags_r    <= hflags_nxt;
      spec_bank_r <= spec_bank_nxt;
      spec_base_r <= spec_base_nxt;
      fs_r        <= fs_nxt;
      for (int i = 0; i < vpfr_pkg::NSTAT; i++) stat_r[i] <= stat_nxt[i];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    code_r <= code_nxt;
    flen_r <= flen_nxt;
    sval_r <= sval_nxt;
    oor_r  <= oor_nxt;
  end

  vpfr_store #(.AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({spec_bank_r, waddr[AW-1:0]}),
    .wr_data (in_data.data_byte),
    .rd_en   (rd_en),
    .rd_addr ({fs_r.cmp_bank, ridx25[AW-1:0]}),
    .rd_data (rd_data)
  );

  assign out_valid             = out_valid_r;
  assign out_data.resp_kind    = kind_r;
  assign out_data.result_code  = code_r;
  assign out_data.frame_length = flen_r;
  assign out_data.read_data    = (kind_r == vpfr_pkg::KIND_BYTE)
                                 ? (oor_r ? 48'd0 : {40'b0, rd_data}) : sval_r;
  assign out_data.out_of_range = oor_r;

endmodule

// ===== rtl/vpfr_checker.sv =====
`include "video_payload_frame_reassembler_assert.svh"

module vpfr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input vpfr_pkg::out_item_t out_data
);

  logic not_frame;
  logic len_zero;

  assign not_frame = out_valid && out_data.result_code != vpfr_pkg::RES_FRAME;
  assign len_zero  = out_data.frame_length == 21'd0;

  `VPFR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `VPFR_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)
  `VPFR_ASSERT_IMP(a_ready_when_free, !out_valid, in_ready)
  `VPFR_ASSERT_IMP(a_len_only_on_frame, not_frame, len_zero)
  `VPFR_ASSERT_IMP(a_oor_zero, out_valid && out_data.out_of_range, out_data.read_data == 48'd0)

endmodule

bind video_payload_frame_reassembler vpfr_checker u_vpfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
